// File: hdl/bdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded drag-box tracker package
// Shared types and codes for the drag-box tracker modules.
// ----------------------------------------------------------------------------
package bdt_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned SizeW  = 15;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned ActW   = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 64;

  typedef enum logic [CmdW-1:0] {
    CMD_START  = 2'd0,
    CMD_MOVE   = 2'd1,
    CMD_BUTTON = 2'd2
  } cmd_t;

  typedef enum logic [ActW-1:0] {
    ACT_SHOW   = 2'd0,
    ACT_MOVE   = 2'd1,
    ACT_FINISH = 2'd2
  } act_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BOX_WIDTH    = 3'd0,
    REG_BOX_HEIGHT   = 3'd1,
    REG_LIMIT_X      = 3'd2,
    REG_LIMIT_Y      = 3'd3,
    REG_LIMIT_WIDTH  = 3'd4,
    REG_LIMIT_HEIGHT = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [SizeW-1:0]  box_width;
    logic [SizeW-1:0]  box_height;
    logic [CoordW-1:0] limit_x;
    logic [CoordW-1:0] limit_y;
    logic [SizeW-1:0]  limit_width;
    logic [SizeW-1:0]  limit_height;
  } cfg_t;

  typedef struct packed {
    logic [CmdW-1:0]   command;
    logic [CoordW-1:0] pointer_x;
    logic [CoordW-1:0] pointer_y;
    logic [CoordW-1:0] origin_x;
    logic [CoordW-1:0] origin_y;
    logic              left_down;
  } item_t;

  typedef struct packed {
    logic [ActW-1:0]   action;
    logic [CoordW-1:0] box_x;
    logic [CoordW-1:0] box_y;
    logic [CoordW-1:0] prior_x;
    logic [CoordW-1:0] prior_y;
  } result_t;

endpackage
`default_nettype wire

// File: hdl/bounded_drag_box_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded drag-box tracker
// Tracks a box dragged by the mouse inside a bounding rectangle.
//
// Channel  Direction  Transaction
// in_      slave      one command item (start, mouse moved, button change)
// out_     master     zero or one result per item (shown, moved, finished)
// cfg_     write      one box size or bound register per write
//
// An item is held in the input register, then its result, if any, is written
// into the output register when the item advances. One item is accepted per
// cycle while the output does not stall; the input register frees as soon as
// the output register is empty or being taken. Reset is synchronous and clears
// the valid flags, the configuration and the drag state. A stalled output
// holds one item in the input register before in_tready drops.
// ----------------------------------------------------------------------------
module bounded_drag_box_tracker
  import bdt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // pointer_x[15:0], pointer_y[31:16], origin_x[47:32], origin_y[63:48],
  // left_down[64], zero[71:65]
  input  wire logic [InDataW-1:0]  in_tdata,
  // command[1:0]
  input  wire logic [CmdW-1:0]     in_tuser,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // box_x[15:0], box_y[31:16], prior_x[47:32], prior_y[63:48]
  output logic [OutDataW-1:0]      out_tdata,
  // action[1:0]
  output logic [ActW-1:0]          out_tuser,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  cfg_t    cfg;
  item_t   in_item_r;
  logic    in_valid_r, in_valid_nxt;
  result_t out_res_r;
  logic    out_valid_r, out_valid_nxt;
  logic    advance;
  logic    res_valid;
  result_t res;

  bdt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = res_valid;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.command   <= in_tuser;
      in_item_r.pointer_x <= in_tdata[15:0];
      in_item_r.pointer_y <= in_tdata[31:16];
      in_item_r.origin_x  <= in_tdata[47:32];
      in_item_r.origin_y  <= in_tdata[63:48];
      in_item_r.left_down <= in_tdata[64];
    end
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  bdt_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .item      (in_item_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.action;
  assign out_tdata  = {out_res_r.prior_y, out_res_r.prior_x,
                       out_res_r.box_y, out_res_r.box_x};

endmodule
`default_nettype wire

// File: hdl/bdt_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Drag-box tracker configuration registers
// Box size and bounding rectangle, written through a plain write port.
// ----------------------------------------------------------------------------
module bdt_cfg_regs
  import bdt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  output cfg_t                     cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_BOX_WIDTH:    cfg_nxt.box_width    = cfg_data[SizeW-1:0];
        REG_BOX_HEIGHT:   cfg_nxt.box_height   = cfg_data[SizeW-1:0];
        REG_LIMIT_X:      cfg_nxt.limit_x      = cfg_data[CoordW-1:0];
        REG_LIMIT_Y:      cfg_nxt.limit_y      = cfg_data[CoordW-1:0];
        REG_LIMIT_WIDTH:  cfg_nxt.limit_width  = cfg_data[SizeW-1:0];
        REG_LIMIT_HEIGHT: cfg_nxt.limit_height = cfg_data[SizeW-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// File: hdl/bdt_clamp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Drag-box tracker axis clamp
// Clamps one coordinate to the low bound, else to bound plus extent minus size.
// ----------------------------------------------------------------------------
module bdt_clamp
  import bdt_pkg::*;
(
  input  wire logic [CoordW-1:0] pos,
  input  wire logic [CoordW-1:0] lo,
  input  wire logic [SizeW-1:0]  extent,
  input  wire logic [SizeW-1:0]  size,
  output logic      [CoordW-1:0] clamped
);

  logic signed [CoordW+1:0] pos_s;
  logic signed [CoordW+1:0] lo_s;
  logic signed [CoordW+1:0] hi_s;

  always_comb begin
    pos_s = signed'({{2{pos[CoordW-1]}}, pos});
    lo_s  = signed'({{2{lo[CoordW-1]}}, lo});
    hi_s  = lo_s + signed'({3'b000, extent}) - signed'({3'b000, size});
    if (pos_s < lo_s) begin
      clamped = lo;
    end else if (pos_s > hi_s) begin
      clamped = hi_s[CoordW-1:0];
    end else begin
      clamped = pos;
    end
  end

endmodule
`default_nettype wire

// File: hdl/bdt_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Drag-box tracker step logic
// Holds the drag state and works out the result of one item.
// ----------------------------------------------------------------------------
module bdt_step
  import bdt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  fire,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  output logic       res_valid,
  output result_t    res
);

  logic              dragging_r, dragging_nxt;
  logic [CoordW-1:0] offset_x_r, offset_x_nxt;
  logic [CoordW-1:0] offset_y_r, offset_y_nxt;
  logic [CoordW-1:0] held_x_r, held_x_nxt;
  logic [CoordW-1:0] held_y_r, held_y_nxt;

  logic [CoordW-1:0] sum_x, sum_y;
  logic [CoordW-1:0] new_x, new_y;
  logic              moved;

  assign sum_x = item.pointer_x + offset_x_r;
  assign sum_y = item.pointer_y + offset_y_r;

  bdt_clamp u_clamp_x (
    .pos     (sum_x),
    .lo      (cfg.limit_x),
    .extent  (cfg.limit_width),
    .size    (cfg.box_width),
    .clamped (new_x)
  );

  bdt_clamp u_clamp_y (
    .pos     (sum_y),
    .lo      (cfg.limit_y),
    .extent  (cfg.limit_height),
    .size    (cfg.box_height),
    .clamped (new_y)
  );

  assign moved = (new_x != held_x_r) || (new_y != held_y_r);

  always_comb begin
    dragging_nxt = dragging_r;
    offset_x_nxt = offset_x_r;
    offset_y_nxt = offset_y_r;
    held_x_nxt   = held_x_r;
    held_y_nxt   = held_y_r;
    res_valid    = 1'b0;
    res.action   = ACT_SHOW;
    res.box_x    = held_x_r;
    res.box_y    = held_y_r;
    res.prior_x  = held_x_r;
    res.prior_y  = held_y_r;
    case (cmd_t'(item.command))
      CMD_START: begin
        offset_x_nxt = item.origin_x - item.pointer_x;
        offset_y_nxt = item.origin_y - item.pointer_y;
        held_x_nxt   = item.origin_x;
        held_y_nxt   = item.origin_y;
        dragging_nxt = item.left_down;
        res_valid    = 1'b1;
        res.action   = item.left_down ? ACT_SHOW : ACT_FINISH;
        res.box_x    = item.origin_x;
        res.box_y    = item.origin_y;
        res.prior_x  = item.origin_x;
        res.prior_y  = item.origin_y;
      end
      CMD_MOVE: begin
        if (dragging_r && moved) begin
          res_valid  = 1'b1;
          res.action = ACT_MOVE;
          res.box_x  = new_x;
          res.box_y  = new_y;
          held_x_nxt = new_x;
          held_y_nxt = new_y;
        end
      end
      CMD_BUTTON: begin
        if (dragging_r && !item.left_down) begin
          dragging_nxt = 1'b0;
          res_valid    = 1'b1;
          res.action   = ACT_FINISH;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dragging_r <= 1'b0;
      offset_x_r <= '0;
      offset_y_r <= '0;
      held_x_r   <= '0;
      held_y_r   <= '0;
    end else if (fire) begin
      dragging_r <= dragging_nxt;
      offset_x_r <= offset_x_nxt;
      offset_y_r <= offset_y_nxt;
      held_x_r   <= held_x_nxt;
      held_y_r   <= held_y_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sim/bounded_drag_box_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded drag-box tracker testbench
// Drives start, mouse and button items into the tracker and predicts every
// report it should make: outline shown, outline moved and drag finished. The
// clamp against the bounding rectangle, offset wrap and the ignored cases are
// covered first by directed items, then by random drag sequences under
// several bound settings, with random idling on both streams but in the last.
// ----------------------------------------------------------------------------
module bounded_drag_box_tracker_tb;
  import bdt_pkg::*;

  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic [CmdW-1:0]     in_tuser = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b1;
  logic [OutDataW-1:0] out_tdata;
  logic [ActW-1:0]     out_tuser;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Predicted drag state and register copy.
  bit          drag_on = 1'b0;
  logic [15:0] grab_dx = '0;
  logic [15:0] grab_dy = '0;
  logic [15:0] box_at_x = '0;
  logic [15:0] box_at_y = '0;
  cfg_t        bounds = '0;

  result_t     box_reports_due[$];
  bit          src_idle_on = 1'b1;
  bit          sink_stall_on = 1'b1;
  int          errors = 0;
  int unsigned items_sent = 0;
  int unsigned items_total = 0;
  int unsigned settings_used = 0;
  int unsigned shows_seen = 0;
  int unsigned moves_seen = 0;
  int unsigned finishes_seen = 0;

  bounded_drag_box_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [15:0] clamp_to_bounds(input logic [15:0] pos,
                                                  input logic [15:0] lo,
                                                  input logic [14:0] extent,
                                                  input logic [14:0] size);
    int p;
    int low;
    int high;
    p = $signed(pos);
    low = $signed(lo);
    high = low + int'(extent) - int'(size);
    if (p < low) return lo;
    if (p > high) return high[15:0];
    return pos;
  endfunction

  function automatic bit track_drag(input item_t it, output result_t res);
    logic [15:0] nx;
    logic [15:0] ny;
    bit made;
    made = 1'b0;
    res = '0;
    if (it.command == CMD_START) begin
      grab_dx = it.origin_x - it.pointer_x;
      grab_dy = it.origin_y - it.pointer_y;
      box_at_x = it.origin_x;
      box_at_y = it.origin_y;
      drag_on = it.left_down;
      res = '{it.left_down ? ACT_SHOW : ACT_FINISH,
              it.origin_x, it.origin_y, it.origin_x, it.origin_y};
      made = 1'b1;
    end else if (drag_on && it.command == CMD_MOVE) begin
      nx = clamp_to_bounds(it.pointer_x + grab_dx, bounds.limit_x,
                           bounds.limit_width, bounds.box_width);
      ny = clamp_to_bounds(it.pointer_y + grab_dy, bounds.limit_y,
                           bounds.limit_height, bounds.box_height);
      if (nx != box_at_x || ny != box_at_y) begin
        res = '{ACT_MOVE, nx, ny, box_at_x, box_at_y};
        box_at_x = nx;
        box_at_y = ny;
        made = 1'b1;
      end
    end else if (drag_on && it.command == CMD_BUTTON && !it.left_down) begin
      drag_on = 1'b0;
      res = '{ACT_FINISH, box_at_x, box_at_y, box_at_x, box_at_y};
      made = 1'b1;
    end
    return made;
  endfunction

  function automatic item_t pointer_event(input logic [1:0] cmd, input logic [15:0] px,
                                          input logic [15:0] py, input logic [15:0] ox,
                                          input logic [15:0] oy, input logic down);
    return '{cmd, px, py, ox, oy, down};
  endfunction

  function automatic logic [15:0] rand16();
    return 16'($urandom);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [15:0] pick_coord(input logic [15:0] lo, input logic [14:0] extent,
                                             input logic [14:0] size);
    int base;
    base = $signed(lo);
    case ($urandom_range(0, 9))
      0: return rand16();
      1: return lo;
      2: return 16'(base - 1);
      3: return 16'(base + int'(extent) - int'(size));
      4: return 16'(base + int'(extent) - int'(size) + 1);
      default: return 16'(base + int'($urandom_range(0, int'(extent) + 64)) - 32);
    endcase
  endfunction

  function automatic cfg_t random_bounds();
    cfg_t c;
    c.box_width    = 15'($urandom_range(0, 300));
    c.box_height   = 15'($urandom_range(0, 300));
    c.limit_x      = 16'(int'($urandom_range(0, 4000)) - 2000);
    c.limit_y      = 16'(int'($urandom_range(0, 4000)) - 2000);
    c.limit_width  = 15'($urandom_range(0, 2000));
    c.limit_height = 15'($urandom_range(0, 2000));
    if ($urandom_range(0, 3) == 0) begin
      c.box_width   = 15'($urandom_range(0, 32767));
      c.limit_x     = rand16();
      c.limit_width = 15'($urandom_range(0, 32767));
    end
    if ($urandom_range(0, 3) == 0) begin
      c.box_height   = 15'($urandom_range(0, 32767));
      c.limit_y      = rand16();
      c.limit_height = 15'($urandom_range(0, 32767));
    end
    return c;
  endfunction

  function automatic void check_field(input string what, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      errors++;
    end
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic apply_bounds(input cfg_t c);
    write_reg(REG_BOX_WIDTH, {1'b0, c.box_width});
    write_reg(REG_BOX_HEIGHT, {1'b0, c.box_height});
    write_reg(REG_LIMIT_X, c.limit_x);
    write_reg(REG_LIMIT_Y, c.limit_y);
    write_reg(REG_LIMIT_WIDTH, {1'b0, c.limit_width});
    write_reg(REG_LIMIT_HEIGHT, {1'b0, c.limit_height});
    cfg_we <= 1'b0;
    bounds = c;
    settings_used++;
  endtask

  task automatic send_item(input item_t it);
    result_t res;
    bit live;
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.command;
    in_tdata  <= {7'd0, it.left_down, it.origin_y, it.origin_x, it.pointer_y, it.pointer_x};
    do @(posedge clk); while (!in_tready);
    live = it.command == CMD_START || (drag_on && it.command != CMD_UNUSED);
    if (track_drag(it, res)) box_reports_due.push_back(res);
    if (live) items_sent++;
    items_total++;
  endtask

  task automatic wait_quiet();
    int unsigned guard;
    in_tvalid <= 1'b0;
    guard = 0;
    while (box_reports_due.size() != 0 && guard < 4000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic test_idle_after_reset();
    send_item(pointer_event(CMD_MOVE, 16'h1234, 16'h5678, 16'h0000, 16'h0000, 1'b1));
    send_item(pointer_event(CMD_BUTTON, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_item(pointer_event(CMD_UNUSED, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1));
  endtask

  task automatic test_drag_basics();
    wait_quiet();
    apply_bounds('{15'd20, 15'd10, 16'hff9c, 16'hffce, 15'd300, 15'd200});
    send_item(pointer_event(CMD_START, 16'd100, 16'd100, 16'd5, 16'd7, 1'b0));
    send_item(pointer_event(CMD_START, 16'd1000, 16'd2000, 16'd10, 16'd20, 1'b1));
    send_item(pointer_event(CMD_MOVE, 16'd1010, 16'd2005, 16'd0, 16'd0, 1'b1));
    send_item(pointer_event(CMD_MOVE, 16'd1010, 16'd2005, 16'd0, 16'd0, 1'b0));
    send_item(pointer_event(CMD_MOVE, 16'h0000, 16'h0000, 16'd0, 16'd0, 1'b1));
    send_item(pointer_event(CMD_MOVE, 16'hffff, 16'hffff, 16'd0, 16'd0, 1'b1));
    send_item(pointer_event(CMD_MOVE, 16'd2000, 16'd3000, 16'd0, 16'd0, 1'b1));
    send_item(pointer_event(CMD_BUTTON, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1));
    send_item(pointer_event(CMD_UNUSED, 16'd5, 16'd5, 16'd5, 16'd5, 1'b0));
    send_item(pointer_event(CMD_START, 16'h0000, 16'h0000, 16'h8000, 16'h7fff, 1'b1));
    send_item(pointer_event(CMD_MOVE, 16'h0000, 16'h0000, 16'd0, 16'd0, 1'b1));
    send_item(pointer_event(CMD_BUTTON, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
    send_item(pointer_event(CMD_MOVE, 16'd50, 16'd60, 16'd0, 16'd0, 1'b1));
    send_item(pointer_event(CMD_BUTTON, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
  endtask

  // Box larger than the bounding rectangle: the upper clamp lies below the
  // lower one and wraps when the sum leaves 16 bits.
  task automatic test_inverted_bounds();
    wait_quiet();
    apply_bounds('{15'h7fff, 15'h7fff, 16'h8000, 16'h7fff, 15'd0, 15'd0});
    send_item(pointer_event(CMD_START, 16'h8000, 16'h7fff, 16'h0000, 16'h0000, 1'b1));
    send_item(pointer_event(CMD_MOVE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    send_item(pointer_event(CMD_MOVE, 16'hffff, 16'hfffe, 16'h0000, 16'h0000, 1'b0));
    send_item(pointer_event(CMD_BUTTON, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
  endtask

  task automatic test_far_bounds();
    wait_quiet();
    apply_bounds('{15'd0, 15'd0, 16'h7fff, 16'h8000, 15'h7fff, 15'h7fff});
    send_item(pointer_event(CMD_START, 16'h0000, 16'hffff, 16'h7fff, 16'h8000, 1'b1));
    send_item(pointer_event(CMD_MOVE, 16'hffff, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    send_item(pointer_event(CMD_MOVE, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 1'b1));
    send_item(pointer_event(CMD_BUTTON, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
  endtask

  task automatic run_drags(input int unsigned goal);
    int unsigned stop_at;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [15:0] px;
    logic [15:0] py;
    stop_at = items_total + goal;
    while (items_total < stop_at) begin
      if ($urandom_range(0, 6) == 0) begin
        send_item(pointer_event(2'($urandom_range(0, 3)), rand16(), rand16(), rand16(),
                                rand16(), rand_bit()));
      end else begin
        px = rand16();
        py = rand16();
        dx = pick_coord(bounds.limit_x, bounds.limit_width, bounds.box_width);
        dy = pick_coord(bounds.limit_y, bounds.limit_height, bounds.box_height);
        send_item(pointer_event(CMD_START, px, py, dx, dy, 1'b1));
        dx = dx - px;
        dy = dy - py;
        repeat ($urandom_range(1, 12)) begin
          case ($urandom_range(0, 9))
            0: send_item(pointer_event(CMD_BUTTON, rand16(), rand16(), rand16(), rand16(),
                                       1'b1));
            1: send_item(pointer_event(CMD_UNUSED, rand16(), rand16(), rand16(), rand16(),
                                       rand_bit()));
            2: send_item(pointer_event(CMD_MOVE, px, py, rand16(), rand16(), rand_bit()));
            default: begin
              px = pick_coord(bounds.limit_x, bounds.limit_width, bounds.box_width) - dx;
              py = pick_coord(bounds.limit_y, bounds.limit_height, bounds.box_height) - dy;
              send_item(pointer_event(CMD_MOVE, px, py, rand16(), rand16(), rand_bit()));
            end
          endcase
        end
        if ($urandom_range(0, 7) != 0)
          send_item(pointer_event(CMD_BUTTON, rand16(), rand16(), rand16(), rand16(), 1'b0));
      end
    end
  endtask

  task automatic test_random_drags();
    for (int phase = 0; phase < 6; phase++) begin
      wait_quiet();
      src_idle_on = phase < 5;
      sink_stall_on = phase < 5;
      case (phase)
        1: apply_bounds('{15'h7fff, 15'h7fff, 16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff});
        2: apply_bounds('{15'd0, 15'd0, 16'h8000, 16'h8000, 15'd0, 15'd0});
        default: apply_bounds(random_bounds());
      endcase
      run_drags(250);
    end
  endtask

  initial begin : sink_pacing
    int unsigned n;
    forever begin
      @(posedge clk);
      if (sink_stall_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 13);
        repeat (n) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (out_tvalid && out_tready) begin
      if (box_reports_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual action %0d data %h",
                 $time, out_tuser, out_tdata);
        errors++;
      end else begin
        want = box_reports_due.pop_front();
        check_field("action", 16'(want.action), 16'(out_tuser));
        check_field("box_x", want.box_x, out_tdata[15:0]);
        check_field("box_y", want.box_y, out_tdata[31:16]);
        check_field("prior_x", want.prior_x, out_tdata[47:32]);
        check_field("prior_y", want.prior_y, out_tdata[63:48]);
        case (want.action)
          ACT_SHOW:   shows_seen++;
          ACT_MOVE:   moves_seen++;
          ACT_FINISH: finishes_seen++;
          default:    ;
        endcase
      end
    end
  end

  initial begin
    #5000000;
    $display("bounded_drag_box_tracker verification failed");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_after_reset();
    test_drag_basics();
    test_inverted_bounds();
    test_far_bounds();
    test_random_drags();
    wait_quiet();
    repeat (8) @(posedge clk);
    if (box_reports_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, box_reports_due.size());
      errors++;
    end
    $display("Sent %0d items (%0d acted on) under %0d bound settings.",
             items_total, items_sent, settings_used);
    $display("Checked %0d outlines shown, %0d moves and %0d finished drags; %0d errors.",
             shows_seen, moves_seen, finishes_seen, errors);
    if (errors == 0) begin
      $display("bounded_drag_box_tracker verification clean");
    end else begin
      $display("bounded_drag_box_tracker verification failed");
    end
    $finish;
  end

endmodule
